// ----- design/dsd_pkg.sv -----
package dsd_pkg;

   localparam int unsigned MAX_SHOWN      = 8;
   localparam int unsigned DEFAULT_DIGITS = 8;
   localparam int unsigned VALUE_W        = 32;
   localparam int unsigned POS_W          = 3;
   localparam int unsigned SEG_W          = 8;
   localparam int unsigned BCD_W          = 4;

   // reciprocal of ten, q = (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hcccc_cccd;
   localparam int unsigned        RECIP_SHIFT = 35;

   // register indexes
   localparam logic REG_COMMON_ANODE = 1'b0;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               overflow;
   } item_type;

   function automatic int unsigned shown_digits(input int unsigned digits);
      int unsigned n;
      n = digits;
      if (n < 1) n = 1;
      if (n > MAX_SHOWN) n = MAX_SHOWN;
      return n;
   endfunction

   // smallest value that needs more than shown digits
   function automatic logic [VALUE_W-1:0] digit_limit(input int unsigned shown);
      logic [VALUE_W-1:0] p;
      p = VALUE_W'(1);
      for (int unsigned i = 0; i < MAX_SHOWN; i++) begin
         if (i < shown) p = VALUE_W'(p * VALUE_W'(10));
      end
      return p;
   endfunction

   // active-low common-anode font, dp dark
   function automatic logic [SEG_W-1:0] anode_font(input logic [BCD_W-1:0] d);
      logic [SEG_W-1:0] code;
      case (d)
         4'd0:    code = 8'hc0;
         4'd1:    code = 8'hf9;
         4'd2:    code = 8'ha4;
         4'd3:    code = 8'hb0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hf8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hff;
      endcase
      return code;
   endfunction

endpackage

// ----- design/dsd_front.sv -----
module dsd_front #(
   parameter int unsigned DIGITS = dsd_pkg::DEFAULT_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [dsd_pkg::VALUE_W-1:0]   value,
   output logic                          full,
   output logic                          item_valid,
   output dsd_pkg::item_type             item,
   input  logic                          item_take
);
   import dsd_pkg::*;

   localparam int unsigned        SHOWN = shown_digits(DIGITS);
   localparam logic [VALUE_W-1:0] LIMIT = digit_limit(SHOWN);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_take;
   item_type   new_item;

   // classify: flag values with more digits than the display shows
   always_comb begin
      new_item.value    = value;
      new_item.overflow = (value >= LIMIT);
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = item_take && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_take;
      count_in  = count_ff;
      if (do_push && !do_take) count_in = count_ff + 2'd1;
      if (!do_push && do_take) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_take_moves: assert property (@(posedge clock) disable iff (reset)
      do_take |=> (rd_ptr_ff != $past(rd_ptr_ff)))
      else $error("take did not advance read pointer");
`endif

endmodule

// ----- design/dsd_back.sv -----
module dsd_back #(
   parameter int unsigned DIGITS = dsd_pkg::DEFAULT_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          common_anode,
   input  logic                          item_valid,
   input  dsd_pkg::item_type             item,
   output logic                          item_take,
   output logic                          empty,
   input  logic                          pop,
   output logic [dsd_pkg::POS_W-1:0]     digit_position,
   output logic [dsd_pkg::SEG_W-1:0]     segment_code,
   output logic                          overflow,
   output logic                          last_digit
);
   import dsd_pkg::*;

   localparam int unsigned      SHOWN   = shown_digits(DIGITS);
   localparam logic [POS_W-1:0] TOP_POS = POS_W'(SHOWN - 1);

   logic               busy_ff, busy_in;
   logic [VALUE_W-1:0] rest_ff, rest_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic               ovf_ff, ovf_in;

   logic               out_valid_ff, out_valid_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;
   logic [BCD_W-1:0]   out_digit_ff, out_digit_in;
   logic               out_ovf_ff, out_ovf_in;
   logic               out_last_ff, out_last_in;

   logic                 have, out_free, produce, last;
   logic [VALUE_W-1:0]   src_rest, quot, rem;
   logic [POS_W-1:0]     src_idx;
   logic                 src_ovf;
   logic [2*VALUE_W-1:0] product;
   logic [SEG_W-1:0]     font;

   assign have     = busy_ff || item_valid;
   assign out_free = !out_valid_ff || pop;
   assign produce  = have && out_free;
   assign item_take = produce && !busy_ff;

   assign src_rest = busy_ff ? rest_ff : item.value;
   assign src_idx  = busy_ff ? idx_ff : '0;
   assign src_ovf  = busy_ff ? ovf_ff : item.overflow;

   // one divide-by-ten step
   assign product = (2*VALUE_W)'(src_rest) * (2*VALUE_W)'(RECIP_TEN);
   assign quot    = VALUE_W'(product >> RECIP_SHIFT);
   assign rem     = src_rest - ((quot << 3) + (quot << 1));
   assign last    = (quot == '0) || (src_idx == TOP_POS);

   always_comb begin
      busy_in      = busy_ff;
      rest_in      = rest_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && !pop;
      out_pos_in   = out_pos_ff;
      out_digit_in = out_digit_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      if (produce) begin
         busy_in      = !last;
         rest_in      = quot;
         idx_in       = src_idx + POS_W'(1);
         ovf_in       = src_ovf;
         out_valid_in = 1'b1;
         out_pos_in   = TOP_POS - src_idx;
         out_digit_in = rem[BCD_W-1:0];
         out_ovf_in   = src_ovf;
         out_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff      <= rest_in;
      ovf_ff       <= ovf_in;
      out_pos_ff   <= out_pos_in;
      out_digit_ff <= out_digit_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign font           = anode_font(out_digit_ff);
   assign empty          = !out_valid_ff;
   assign digit_position = out_pos_ff;
   assign segment_code   = common_anode ? font : ~font;
   assign overflow       = out_ovf_ff;
   assign last_digit     = out_last_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> (out_valid_ff && $stable(out_digit_ff)
                                   && $stable(out_pos_ff)))
      else $error("waiting result overwritten");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (produce && last) |=> !busy_ff)
      else $error("sequencer still busy after last digit");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= TOP_POS && idx_ff != '0))
      else $error("digit index out of range");
   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_digit_ff <= BCD_W'(9)))
      else $error("digit not decimal");
`endif

endmodule

// ----- design/decimal_seven_segment_display.sv -----
// binary to decimal seven-segment display driver. each number pushed on the
// request queue gives one result per significant decimal digit, least
// significant first, with its display position (rightmost is DIGITS-1, at
// most 7), its segment code (a..g at bits 0..6, dp dark at bit 7) and a last
// flag on the final digit. leading zeros are suppressed and zero shows one
// '0'. values with more digits than the display shows give only the lowest
// digits and carry the overflow flag on every result. register 0 at byte
// address 0 is common_anode (reset 1): 1 gives active-low anode codes, 0 the
// inverted cathode codes. the digit sequencer does one divide-by-ten step
// per cycle while the result register is empty or being popped;
// a two-entry queue lets new numbers arrive while digits are still going out
module decimal_seven_segment_display #(
   parameter int unsigned DIGITS = dsd_pkg::DEFAULT_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request queue
   input  logic                          push,
   output logic                          full,
   input  logic [dsd_pkg::VALUE_W-1:0]   req_value,
   // result queue
   output logic                          empty,
   input  logic                          pop,
   output logic [dsd_pkg::POS_W-1:0]     rsp_digit_position,
   output logic [dsd_pkg::SEG_W-1:0]     rsp_segment_code,
   output logic                          rsp_overflow,
   output logic                          rsp_last_digit,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import dsd_pkg::*;

   logic     common_anode_ff, common_anode_in;
   logic     csr_write, csr_hit;
   logic     item_valid, item_take;
   item_type item;

   // register decode: word index is paddr[2], anything past word 0 is empty
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == REG_COMMON_ANODE);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      common_anode_in = common_anode_ff;
      if (csr_write && csr_hit) common_anode_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         common_anode_ff <= 1'b1;
      end else begin
         common_anode_ff <= common_anode_in;
      end
   end

   // read data, low address bits are ignored within the word
   assign prdata = csr_hit ? {31'd0, common_anode_ff} : 32'd0;

   // front: accept, flag overflow, queue
   dsd_front #(
      .DIGITS     (DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .value      (req_value),
      .full       (full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // back: digit sequencer and result register
   dsd_back #(
      .DIGITS         (DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .common_anode   (common_anode_ff),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take),
      .empty          (empty),
      .pop            (pop),
      .digit_position (rsp_digit_position),
      .segment_code   (rsp_segment_code),
      .overflow       (rsp_overflow),
      .last_digit     (rsp_last_digit)
   );

endmodule

// ----- tb/tb_decimal_seven_segment_display.sv -----
module tb_decimal_seven_segment_display;
   timeunit 1ns;
   timeprecision 1ps;

   // display width used for the dut and for the digit predictor
   localparam int unsigned DISPLAY_DIGITS = 8;
   localparam int unsigned CYCLE_LIMIT    = 100000;
   localparam int unsigned PRINT_LIMIT    = 30;

   // register map: byte address is four times the register index
   localparam logic [2:0] ADDR_COMMON_ANODE = 3'(4 * dsd_pkg::REG_COMMON_ANODE);
   // first address past the register list, writes there must be dropped
   localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

   typedef struct packed {
      logic [dsd_pkg::POS_W-1:0] position;
      logic [dsd_pkg::SEG_W-1:0] segments;
      logic                      ovf;
      logic                      last;
   } digit_result_type;

   // clock, reset and dut ports, the driven ones at known values from time zero
   logic                          clock   = 1'b0;
   logic                          reset   = 1'b1;
   logic                          push    = 1'b0;
   logic                          full;
   logic [dsd_pkg::VALUE_W-1:0]   req_value = '0;
   logic                          empty;
   logic                          pop     = 1'b0;
   logic [dsd_pkg::POS_W-1:0]     rsp_digit_position;
   logic [dsd_pkg::SEG_W-1:0]     rsp_segment_code;
   logic                          rsp_overflow;
   logic                          rsp_last_digit;
   logic                          psel    = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite  = 1'b0;
   logic [2:0]                    paddr   = '0;
   logic [31:0]                   pwdata  = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   // digit results still owed by the dut, oldest first
   digit_result_type expected_digits[$];

   // local copy of the polarity register, reset value is anode mode
   logic anode_mode = 1'b1;

   // idle_enable serves sender and receiver, the two counters only the receiver
   bit          idle_enable = 1'b1;
   int unsigned hold_cycles = 0;
   int unsigned stall_left  = 0;

   // run statistics
   int unsigned cycle_count    = 0;
   int unsigned mismatches     = 0;
   int unsigned numbers_sent   = 0;
   int unsigned digits_checked = 0;
   int unsigned csr_writes     = 0;
   int unsigned input_stalls   = 0;
   int unsigned overflow_seen  = 0;
   int unsigned cathode_digits = 0;

   decimal_seven_segment_display #(
      .DIGITS(DISPLAY_DIGITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_value          (req_value),
      .empty              (empty),
      .pop                (pop),
      .rsp_digit_position (rsp_digit_position),
      .rsp_segment_code   (rsp_segment_code),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_digit     (rsp_last_digit),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digits still owed", cycle_count,
                  expected_digits.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------------------
   // digit predictor
   // ---------------------------------------------------------------------------

   // active-low common-anode glyphs, dp segment dark
   function automatic logic [dsd_pkg::SEG_W-1:0] glyph_for(input int unsigned d);
      logic [dsd_pkg::SEG_W-1:0] g;
      case (d)
         0:       g = 8'hc0;
         1:       g = 8'hf9;
         2:       g = 8'ha4;
         3:       g = 8'hb0;
         4:       g = 8'h99;
         5:       g = 8'h92;
         6:       g = 8'h82;
         7:       g = 8'hf8;
         8:       g = 8'h80;
         default: g = 8'h90;
      endcase
      return g;
   endfunction

   // queue up the digit transfers that one accepted number must produce
   function automatic void predict_digits(input logic [dsd_pkg::VALUE_W-1:0] value);
      int unsigned      shown;
      int unsigned      count;
      int unsigned      digs[8];
      logic [31:0]      rest;
      logic             ovf;
      digit_result_type r;
      shown = DISPLAY_DIGITS;
      if (shown < 1) shown = 1;
      if (shown > 8) shown = 8;
      count = 0;
      ovf   = 1'b0;
      rest  = value;
      // zero still lights one '0' at the rightmost position
      if (rest == 0) begin
         digs[0] = 0;
         count   = 1;
      end
      while (rest != 0) begin
         // digits beyond the display width only raise overflow
         if (count >= shown) begin
            ovf = 1'b1;
            break;
         end
         digs[count] = rest % 10;
         rest        = rest / 10;
         count++;
      end
      for (int unsigned k = 0; k < count; k++) begin
         r.position = dsd_pkg::POS_W'(shown - 1 - k);
         r.segments = anode_mode ? glyph_for(digs[k]) : ~glyph_for(digs[k]);
         r.ovf      = ovf;
         r.last     = (k + 1 == count);
         expected_digits.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // result side: random pop with stalls, long hold-off on request, checking
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      digit_result_type want;
      // a transfer happened at this edge if pop and !empty were both seen
      if (!reset && pop && !empty) begin
         digits_checked++;
         if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("digit with nothing owed: pos %0d seg %02h",
                                      rsp_digit_position, rsp_segment_code));
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_position != want.position)
               report_mismatch($sformatf("position %0d, expected %0d",
                                         rsp_digit_position, want.position));
            if (rsp_segment_code != want.segments)
               report_mismatch($sformatf("segments %02h, expected %02h",
                                         rsp_segment_code, want.segments));
            if (rsp_overflow != want.ovf)
               report_mismatch($sformatf("overflow %0b, expected %0b",
                                         rsp_overflow, want.ovf));
            if (rsp_last_digit != want.last)
               report_mismatch($sformatf("last flag %0b, expected %0b",
                                         rsp_last_digit, want.last));
            if (want.ovf && want.last) overflow_seen++;
            if (!want.segments[7]) cathode_digits++;
         end
      end
      // pick pop for the next edge: hold-off first, then random stalls
      if (hold_cycles > 0) begin
         hold_cycles--;
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 99) < 3) begin
         stall_left = $urandom_range(0, 3);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // offer one number, with an occasional gap first; returns once accepted,
   // leaving push high so back-to-back transfers follow without push dropping
   task automatic send_value(input logic [dsd_pkg::VALUE_W-1:0] value);
      int unsigned gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 5);
      repeat (gap) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push      <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (full) begin
         input_stalls++;
         @(posedge clock);
      end
      numbers_sent++;
      predict_digits(value);
   endtask

   // stop offering and wait until every owed digit has come out
   task automatic settle_idle();
      push <= 1'b0;
      @(posedge clock);
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   // numbers spread over every digit count, with some full-range words
   function automatic logic [dsd_pkg::VALUE_W-1:0] random_value();
      int unsigned n;
      longint      lo;
      longint      hi;
      n = $urandom_range(0, 11);
      if (n == 0) return '0;
      if (n == 11) return $urandom;
      lo = 1;
      for (int unsigned i = 1; i < n; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'hffff_ffff) hi = 64'hffff_ffff;
      return dsd_pkg::VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
   endfunction

   // ---------------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------------

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_writes++;
      // only the polarity register exists, its upper bits are dropped
      if (addr == ADDR_COMMON_ANODE) anode_mode = data[0];
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [2:0] addr, input logic [31:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // read data is sampled at the access edge
      if (prdata !== want)
         report_mismatch($sformatf("register read %08h, expected %08h", prdata, want));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   task automatic test_reset_polarity();
      // polarity must come out of reset in anode mode
      csr_read_check(ADDR_COMMON_ANODE, 32'd1);
   endtask

   task automatic test_anode_directed();
      logic [31:0] vals[$];
      // zero, single digits, digit-count boundaries, all glyphs, overflow and
      // the all-ones and all-zeros words
      vals = {32'd0, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100, 32'd10000000,
              32'd12345678, 32'd98765432, 32'd99999999, 32'd100000000,
              32'd1234567890, 32'h8000_0000, 32'hffff_ffff, 32'd24680, 32'd13579};
      foreach (vals[i]) send_value(vals[i]);
      settle_idle();
   endtask

   task automatic test_cathode_polarity();
      logic [31:0] vals[$];
      // bit 0 clear with every upper bit set: upper bits must be ignored
      csr_write(ADDR_COMMON_ANODE, 32'hffff_fffe);
      csr_read_check(ADDR_COMMON_ANODE, 32'd0);
      vals = {32'd0, 32'd8, 32'd1023, 32'd99999999, 32'hffff_ffff};
      foreach (vals[i]) send_value(vals[i]);
      settle_idle();
   endtask

   task automatic test_unmapped_register();
      // a write past the register list must leave cathode mode in place
      csr_write(ADDR_UNMAPPED, 32'hffff_ffff);
      csr_read_check(ADDR_COMMON_ANODE, 32'd0);
      send_value(32'd4);
      send_value(32'd56);
      send_value(32'd4000000000);
      settle_idle();
      // back to anode mode, again with junk in the upper bits
      csr_write(ADDR_COMMON_ANODE, 32'h8000_0001);
      csr_read_check(ADDR_COMMON_ANODE, 32'd1);
   endtask

   task automatic test_backpressure();
      // receiver holds off long enough for the dut to fill and raise full,
      // while the sender keeps offering back to back
      idle_enable = 1'b0;
      hold_cycles = 250;
      repeat (16) send_value(random_value());
      // sender then pauses until the last owed digit has drained
      settle_idle();
      idle_enable = 1'b1;
   endtask

   task automatic test_random_values();
      logic settings[4];
      settings = '{1'b1, 1'b0, 1'b1, 1'b0};
      foreach (settings[p]) begin
         settle_idle();
         csr_write(ADDR_COMMON_ANODE,
                   {31'($urandom_range(0, 32'h7fff_ffff)), settings[p]});
         // first phase runs with no idling on either side
         idle_enable = (p != 0);
         repeat (18) send_value(random_value());
      end
      settle_idle();
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_polarity();
      test_anode_directed();
      test_cathode_polarity();
      test_unmapped_register();
      test_backpressure();
      test_random_values();

      // tail: catch any stray digit transfers after the last owed one
      settle_idle();
      repeat (20) @(posedge clock);
      if (expected_digits.size() != 0)
         report_mismatch($sformatf("%0d digits never arrived", expected_digits.size()));

      $display("covered %0d numbers, %0d digit transfers (%0d cathode, %0d overflowed numbers)",
               numbers_sent, digits_checked, cathode_digits, overflow_seen);
      $display("%0d register writes, %0d cycles with the request side held off by full",
               csr_writes, input_stalls);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/dsd_pkg.sv
design/dsd_front.sv
design/dsd_back.sv
design/decimal_seven_segment_display.sv
tb/tb_decimal_seven_segment_display.sv
